/* rtl/bba_pkg.sv */
// Shared constants and codes of the bitmap block allocator.
package bba_pkg;

    localparam int DEF_NUM_BLOCKS = 1024;
    localparam int DEF_ADDR_WIDTH = 32;

    localparam int BS_WIDTH   = 17;
    localparam int POOL_WIDTH = 11;
    localparam int CNT_WIDTH  = 11;
    localparam int CFG_WIDTH  = 32;

    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_FREE  = 2'd1;
    localparam logic [1:0] CMD_INIT  = 2'd2;

    localparam logic [1:0] CFG_BASE  = 2'd0;
    localparam logic [1:0] CFG_BSIZE = 2'd1;
    localparam logic [1:0] CFG_POOL  = 2'd2;

    localparam logic [1:0] TAG_FREE = 2'd0;
    localparam logic [1:0] TAG_RSV  = 2'd1;

    localparam logic [BS_WIDTH-1:0]   RST_BSIZE = 17'd16;
    localparam logic [POOL_WIDTH-1:0] RST_POOL  = 11'd1024;
    localparam logic [CNT_WIDTH-1:0]  USED_MAX  = 11'd2047;

endpackage

/* rtl/bitmap_block_allocator.sv */
// Top level of the bitmap block allocator: control sequencer and tag memory.
//
// Usage: commands arrive on the input channel (i_in_valid / o_in_stall) with
// fields i_command, i_request_size and i_free_address; every command gives one
// result transfer on the output channel (o_out_valid / i_out_stall). The pool
// setup is written through i_cfg_we / i_cfg_index / i_cfg_data while idle.
// Each block carries a 2-bit tag in a single-port-write, registered-read
// memory. One command is worked on at a time; o_in_stall is high while busy.
// Sequencing: allocate, free and initialize start with a bit-serial divide
// (skipped for an allocate of size zero or a free below the base). Allocate
// then scans the tags one per cycle (up to the pool size) and writes the run
// one block per cycle. Free walks the run one block per cycle. Initialize
// rewrites every tag entry.
// After reset a clearing pass zeroes every tag; no input
// transfer is taken meanwhile, though configuration writes are.
// A finished result sits in the output register; while the receiver stalls
// a further command may be taken, and its result waits until the register
// is free.
module bitmap_block_allocator #(
    parameter int NUM_BLOCKS = bba_pkg::DEF_NUM_BLOCKS,
    parameter int ADDR_WIDTH = bba_pkg::DEF_ADDR_WIDTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [1:0]                      i_cfg_index,
    input  logic [bba_pkg::CFG_WIDTH-1:0]   i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [1:0]                      i_command,
    input  logic [31:0]                     i_request_size,
    input  logic [31:0]                     i_free_address,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_success,
    output logic [31:0]                     o_result_address,
    output logic [bba_pkg::CNT_WIDTH-1:0]   o_blocks_changed,
    output logic [bba_pkg::CNT_WIDTH-1:0]   o_used_blocks
);
    localparam int BSW = bba_pkg::BS_WIDTH;
    localparam int OW  = bba_pkg::CNT_WIDTH;
    localparam int IW  = $clog2(NUM_BLOCKS);
    localparam int CW  = $clog2(NUM_BLOCKS + 1);
    localparam int EW  = (CW > OW) ? CW : OW;
    localparam int DW  = (ADDR_WIDTH > 32) ? ADDR_WIDTH : 32;
    localparam int PW  = CW + BSW;
    localparam int SW  = (ADDR_WIDTH > PW) ? ADDR_WIDTH : PW;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SWEEP = 4'd1;
    localparam logic [3:0] S_DIV   = 4'd2;
    localparam logic [3:0] S_SCAN  = 4'd3;
    localparam logic [3:0] S_RIGHT = 4'd4;
    localparam logic [3:0] S_AWR   = 4'd5;
    localparam logic [3:0] S_AMUL  = 4'd6;
    localparam logic [3:0] S_AADD  = 4'd7;
    localparam logic [3:0] S_FRD   = 4'd8;
    localparam logic [3:0] S_FWALK = 4'd9;
    localparam logic [3:0] S_DONE  = 4'd10;

    function automatic logic [1:0] pick_tag(input logic [1:0] l, input logic [1:0] r);
        logic [1:0] t;
        t = 2'd1;
        if (t == l || t == r) t = 2'd2;
        if (t == l || t == r) t = 2'd3;
        return t;
    endfunction

    // Configuration registers.
    logic [31:0]     r_base;
    logic [BSW-1:0]  r_bs;
    logic [OW-1:0]   r_pool;

    // Sequencer state.
    logic [3:0]      r_state;
    logic            r_boot;
    logic [1:0]      r_cmd;
    logic [IW-1:0]   r_sw;
    logic [CW-1:0]   r_need;
    logic [CW-1:0]   r_chk;
    logic [CW-1:0]   r_run;
    logic [CW-1:0]   r_start;
    logic [CW-1:0]   r_idx;
    logic [CW-1:0]   r_blk;
    logic [CW-1:0]   r_cnt;
    logic [1:0]      r_left;
    logic [1:0]      r_t;
    logic [PW-1:0]   r_prod;
    logic [OW-1:0]   r_used;
    logic            r_ok;
    logic [31:0]     r_addr;
    logic [CW-1:0]   r_chg;

    // Tag memory.
    logic [1:0]      mem [NUM_BLOCKS];
    logic [1:0]      r_rdata;
    logic            mem_we;
    logic [IW-1:0]   mem_waddr;
    logic [1:0]      mem_wdata;
    logic [IW-1:0]   mem_raddr;

    // Divider hookup.
    logic            div_start;
    logic [DW-1:0]   div_dividend;
    logic            div_done;
    logic [DW-1:0]   div_q;
    logic            div_nz;

    // Derived values.
    logic [BSW-1:0]        bs_eff;
    logic [EW-1:0]         pool_ext;
    logic [CW-1:0]         pool_eff;
    logic                  in_acc;
    logic [DW-1:0]         faddr_ext;
    logic [DW-1:0]         base_ext;
    logic [ADDR_WIDTH-1:0] a_aw;
    logic [ADDR_WIDTH-1:0] b_aw;
    logic                  a_ge_b;
    logic [ADDR_WIDTH-1:0] diff_aw;
    logic [DW:0]           need_w;
    logic [DW:0]           pool_w;
    logic [EW-1:0]         free_cnt;
    logic [CW-1:0]         chk_p1;
    logic [CW-1:0]         idx_p1;
    logic [CW-1:0]         run_p1;
    logic [EW:0]           used_sum;
    logic [CW-1:0]         fchg;
    logic [EW-1:0]         used_dif;
    logic [SW-1:0]         addr_sum;
    logic [DW-1:0]         addr_ext;
    logic [EW-1:0]         chg_ext;
    logic [EW-1:0]         need_ext;

    assign bs_eff    = (r_bs == '0) ? BSW'(1) : r_bs;
    assign pool_ext  = EW'(r_pool);
    assign pool_eff  = (pool_ext > EW'(NUM_BLOCKS)) ? CW'(NUM_BLOCKS) : pool_ext[CW-1:0];
    assign in_acc    = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = r_state != S_IDLE;

    assign faddr_ext = DW'(i_free_address);
    assign base_ext  = DW'(r_base);
    assign a_aw      = faddr_ext[ADDR_WIDTH-1:0];
    assign b_aw      = base_ext[ADDR_WIDTH-1:0];
    assign a_ge_b    = a_aw >= b_aw;
    assign diff_aw   = a_aw - b_aw;

    assign need_w    = {1'b0, div_q} + (DW+1)'(div_nz);
    assign pool_w    = (DW+1)'(pool_eff);
    assign free_cnt  = (EW'(r_used) < EW'(pool_eff)) ? EW'(pool_eff) - EW'(r_used) : '0;
    assign chk_p1    = r_chk + CW'(1);
    assign idx_p1    = r_idx + CW'(1);
    assign run_p1    = r_run + CW'(1);
    assign used_sum  = (EW+1)'(r_used) + (EW+1)'(r_need);
    assign fchg      = r_idx - r_blk;
    assign used_dif  = EW'(r_used) - EW'(fchg);
    assign addr_sum  = SW'(b_aw) + SW'(r_prod);
    assign addr_ext  = DW'(addr_sum[ADDR_WIDTH-1:0]);
    assign need_ext  = EW'(r_need);

    always_comb begin
        div_start    = 1'b0;
        div_dividend = '0;
        if (in_acc) begin
            case (i_command)
                bba_pkg::CMD_INIT: begin
                    div_start    = 1'b1;
                    div_dividend = DW'(pool_eff);
                end
                bba_pkg::CMD_ALLOC: begin
                    div_start    = i_request_size != '0;
                    div_dividend = DW'(i_request_size);
                end
                bba_pkg::CMD_FREE: begin
                    div_start    = a_ge_b;
                    div_dividend = DW'(diff_aw);
                end
                default: ;
            endcase
        end
    end

    bba_div #(.DW(DW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (bs_eff),
        .o_done     (div_done),
        .o_quotient (div_q),
        .o_rem_nz   (div_nz)
    );

    // Memory port control.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_idx[IW-1:0];
        mem_wdata = bba_pkg::TAG_FREE;
        mem_raddr = '0;
        unique case (r_state)
            S_SWEEP: begin
                mem_we    = 1'b1;
                mem_waddr = r_sw;
                mem_wdata = (CW'(r_sw) < r_need) ? bba_pkg::TAG_RSV : bba_pkg::TAG_FREE;
            end
            S_DIV: begin
                mem_raddr = (r_cmd == bba_pkg::CMD_FREE) ? div_q[IW-1:0] : '0;
            end
            S_SCAN: begin
                mem_raddr = chk_p1[IW-1:0];
            end
            S_AWR: begin
                mem_we    = 1'b1;
                mem_wdata = r_t;
            end
            S_FRD: begin
                mem_we    = r_rdata != bba_pkg::TAG_FREE;
                mem_raddr = idx_p1[IW-1:0];
            end
            S_FWALK: begin
                mem_we    = (r_idx < pool_eff) && (r_rdata == r_t);
                mem_raddr = idx_p1[IW-1:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= mem[mem_raddr];
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
            r_bs   <= bba_pkg::RST_BSIZE;
            r_pool <= bba_pkg::RST_POOL;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                bba_pkg::CFG_BASE:  r_base <= i_cfg_data;
                bba_pkg::CFG_BSIZE: r_bs   <= i_cfg_data[BSW-1:0];
                bba_pkg::CFG_POOL:  r_pool <= i_cfg_data[OW-1:0];
                default: ;
            endcase
        end
    end

    // Command sequencer and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_SWEEP;
            r_boot      <= 1'b1;
            r_sw        <= '0;
            r_need      <= '0;
            r_used      <= '0;
            o_out_valid <= 1'b0;
        end else begin
            // The finished state loads the result register itself.
            if (!i_out_stall && (r_state != S_DONE)) begin
                o_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_cmd  <= i_command;
                        r_ok   <= 1'b0;
                        r_addr <= '0;
                        r_chg  <= '0;
                        r_state <= div_start ? S_DIV : S_DONE;
                    end
                end
                S_SWEEP: begin
                    r_sw <= r_sw + IW'(1);
                    if (r_sw == IW'(NUM_BLOCKS - 1)) begin
                        r_sw <= '0;
                        if (r_boot) begin
                            r_boot  <= 1'b0;
                            r_state <= S_IDLE;
                        end else begin
                            r_used  <= need_ext[OW-1:0];
                            r_ok    <= 1'b1;
                            r_chg   <= r_need;
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        case (r_cmd)
                            bba_pkg::CMD_INIT: begin
                                r_need  <= (need_w > pool_w) ? pool_eff : need_w[CW-1:0];
                                r_sw    <= '0;
                                r_state <= S_SWEEP;
                            end
                            bba_pkg::CMD_ALLOC: begin
                                if (need_w > (DW+1)'(free_cnt)) begin
                                    r_state <= S_DONE;
                                end else begin
                                    r_need  <= need_w[CW-1:0];
                                    r_chk   <= '0;
                                    r_run   <= '0;
                                    r_start <= '0;
                                    r_left  <= bba_pkg::TAG_FREE;
                                    r_state <= S_SCAN;
                                end
                            end
                            default: begin
                                if ({1'b0, div_q} >= pool_w) begin
                                    r_state <= S_DONE;
                                end else begin
                                    r_idx   <= div_q[CW-1:0];
                                    r_blk   <= div_q[CW-1:0];
                                    r_state <= S_FRD;
                                end
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (r_chk >= pool_eff) begin
                        r_state <= S_DONE;
                    end else begin
                        r_chk <= chk_p1;
                        if (r_rdata == bba_pkg::TAG_FREE) begin
                            r_run <= run_p1;
                            if (run_p1 == r_need) begin
                                r_state <= S_RIGHT;
                            end
                        end else begin
                            r_run   <= '0;
                            r_start <= chk_p1;
                            r_left  <= r_rdata;
                        end
                    end
                end
                S_RIGHT: begin
                    // r_chk now points just past the run; its tag is the right neighbor.
                    r_t     <= pick_tag(r_left,
                                        (r_chk < pool_eff) ? r_rdata : bba_pkg::TAG_FREE);
                    r_idx   <= r_start;
                    r_cnt   <= '0;
                    r_state <= S_AWR;
                end
                S_AWR: begin
                    r_idx <= idx_p1;
                    r_cnt <= r_cnt + CW'(1);
                    if (r_cnt + CW'(1) == r_need) begin
                        r_state <= S_AMUL;
                    end
                end
                S_AMUL: begin
                    r_prod  <= PW'(r_start) * PW'(bs_eff);
                    r_state <= S_AADD;
                end
                S_AADD: begin
                    r_addr  <= addr_ext[31:0];
                    r_used  <= (used_sum > (EW+1)'(bba_pkg::USED_MAX)) ?
                               bba_pkg::USED_MAX : used_sum[OW-1:0];
                    r_ok    <= 1'b1;
                    r_chg   <= r_need;
                    r_state <= S_DONE;
                end
                S_FRD: begin
                    if (r_rdata == bba_pkg::TAG_FREE) begin
                        r_state <= S_DONE;
                    end else begin
                        r_t     <= r_rdata;
                        r_idx   <= idx_p1;
                        r_state <= S_FWALK;
                    end
                end
                S_FWALK: begin
                    if ((r_idx < pool_eff) && (r_rdata == r_t)) begin
                        r_idx <= idx_p1;
                    end else begin
                        r_chg   <= fchg;
                        r_used  <= (EW'(r_used) > EW'(fchg)) ? used_dif[OW-1:0] : '0;
                        r_ok    <= 1'b1;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!o_out_valid || !i_out_stall) begin
                        o_out_valid      <= 1'b1;
                        o_success        <= r_ok;
                        o_result_address <= r_addr;
                        o_blocks_changed <= chg_ext[OW-1:0];
                        o_used_blocks    <= r_used;
                        r_state          <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign chg_ext = EW'(r_chg);

endmodule

/* rtl/bba_div.sv */
// Restoring divider, one quotient bit per cycle, with a remainder-nonzero flag.
module bba_div #(
    parameter int DW = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [DW-1:0]                 i_dividend,
    input  logic [bba_pkg::BS_WIDTH-1:0]  i_divisor,
    output logic                          o_done,
    output logic [DW-1:0]                 o_quotient,
    output logic                          o_rem_nz
);
    localparam int BSW = bba_pkg::BS_WIDTH;
    localparam int KW  = $clog2(DW + 1);

    logic [DW-1:0]  r_q;
    logic [BSW-1:0] r_rem;
    logic [BSW-1:0] r_div;
    logic [KW-1:0]  r_cnt;
    logic           r_busy;
    logic           r_done;
    logic [BSW:0]   sh;
    logic           ge;

    assign sh = {r_rem, r_q[DW-1]};
    assign ge = sh >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_q    <= i_dividend;
                r_rem  <= '0;
                r_div  <= i_divisor;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_rem <= ge ? BSW'(sh - {1'b0, r_div}) : sh[BSW-1:0];
                r_q   <= {r_q[DW-2:0], ge};
                r_cnt <= r_cnt + KW'(1);
                if (r_cnt == KW'(DW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;
    assign o_rem_nz   = r_rem != '0;

endmodule

/* dv/bitmap_block_allocator_tb.sv */
// Self-checking testbench for the bitmap block allocator: predicts every allocator response.
`timescale 1ns / 1ps

module bitmap_block_allocator_tb;

    localparam int NBLK = 1024;
    localparam int WATCHDOG_LIMIT = 200000;

    // Result of one command as the predictor sees it.
    typedef struct packed {
        logic        ok;
        logic [31:0] addr;
        logic [10:0] changed;
        logic [10:0] used;
    } t_alloc_resp;

    // Scoreboard: a copy of the pool state and a queue of pending responses.
    class t_alloc_scoreboard;
        logic [1:0]  tags[NBLK];
        logic [10:0] used_cnt;
        logic [31:0] base;
        logic [16:0] bsize;
        logic [10:0] pool;
        t_alloc_resp pending[$];
        int          mismatches;

        function new();
            foreach (tags[k]) tags[k] = bba_pkg::TAG_FREE;
            used_cnt = '0;
            base = '0;
            bsize = bba_pkg::RST_BSIZE;
            pool = bba_pkg::RST_POOL;
            mismatches = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                bba_pkg::CFG_BASE:  base = val;
                bba_pkg::CFG_BSIZE: bsize = val[16:0];
                bba_pkg::CFG_POOL:  pool = val[10:0];
                default: ;
            endcase
        endfunction

        // Works out the response of one accepted command and updates the pool.
        function void note_command(logic [1:0] cmd, logic [31:0] size, logic [31:0] faddr);
            longint unsigned bs, np, rsv, free_bytes, need, i, n, j, blk, acc;
            logic [1:0] lt, rt, t;
            t_alloc_resp r;
            bs = (bsize == 0) ? 1 : bsize;
            np = (pool > NBLK) ? NBLK : pool;
            r = '0;
            if (cmd == bba_pkg::CMD_INIT) begin
                rsv = (np + bs - 1) / bs;
                if (rsv > np) rsv = np;
                foreach (tags[k]) tags[k] = (k < rsv) ? bba_pkg::TAG_RSV : bba_pkg::TAG_FREE;
                used_cnt = rsv[10:0];
                r.ok = 1'b1;
                r.changed = rsv[10:0];
            end else if (cmd == bba_pkg::CMD_ALLOC) begin
                free_bytes = (used_cnt < np) ? (np - used_cnt) * bs : 0;
                if (size != 0 && size <= free_bytes) begin
                    need = (size + bs - 1) / bs;
                    i = 0;
                    while (i < np && need <= np - i) begin
                        n = 0;
                        while (n < need && tags[i + n] == bba_pkg::TAG_FREE) n++;
                        if (n == need) begin
                            lt = (i == 0) ? bba_pkg::TAG_FREE : tags[i - 1];
                            rt = (i + n < np) ? tags[i + n] : bba_pkg::TAG_FREE;
                            t = 2'd1;
                            while (t == lt || t == rt) t++;
                            for (j = i; j < i + n; j++) tags[j] = t;
                            acc = used_cnt + n;
                            used_cnt = (acc > bba_pkg::USED_MAX) ? bba_pkg::USED_MAX : acc[10:0];
                            r.ok = 1'b1;
                            r.changed = n[10:0];
                            acc = base + i * bs;
                            r.addr = acc[31:0];
                            break;
                        end
                        i += n + 1;
                    end
                end
            end else if (cmd == bba_pkg::CMD_FREE) begin
                if (faddr >= base) begin
                    blk = (longint'(faddr) - longint'(base)) / bs;
                    if (blk < np && tags[blk] != bba_pkg::TAG_FREE) begin
                        t = tags[blk];
                        j = blk;
                        while (j < np && tags[j] == t) begin
                            tags[j] = bba_pkg::TAG_FREE;
                            j++;
                        end
                        n = j - blk;
                        acc = (used_cnt > n) ? used_cnt - n : 0;
                        used_cnt = acc[10:0];
                        r.ok = 1'b1;
                        r.changed = n[10:0];
                    end
                end
            end
            r.used = used_cnt;
            pending.push_back(r);
        endfunction

        function void check_response(t_alloc_resp got);
            t_alloc_resp want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected response %p", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: response mismatch expected %p actual %p", want, got);
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  command = '0;
    logic [31:0] request_size = '0;
    logic [31:0] free_address = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        success;
    logic [31:0] result_address;
    logic [10:0] blocks_changed;
    logic [10:0] used_blocks;

    t_alloc_scoreboard board = new();
    bit          calm = 1'b0;       // no idling on either side near the end
    int          quiet_cycles = 0;
    logic [31:0] live_addrs[$];     // addresses handed out and not yet freed

    always #1 clk = ~clk;

    bitmap_block_allocator dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_command(command), .i_request_size(request_size),
        .i_free_address(free_address),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_success(success), .o_result_address(result_address),
        .o_blocks_changed(blocks_changed), .o_used_blocks(used_blocks)
    );

    // Every result transfer is checked at the rising edge; a successful
    // allocation at a nonzero address also feeds the address list that later frees use.
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            board.check_response({success, result_address, blocks_changed, used_blocks});
            if (success && blocks_changed != 0 && result_address != 0 || success && !$isunknown(result_address) && result_address != 0)
                live_addrs.push_back(result_address);
        end
    end

    // Receiver stalls in random bursts, left out once the run is calm.
    initial begin
        int k;
        forever begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 7) == 0) begin
                out_stall <= 1'b1;
                for (k = $urandom_range(1, 18); k > 0; k--) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // The watchdog counts cycles with no transfer on either channel.
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // One register write; the task returns with the write enable low.
    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        board.write_reg(idx, val);
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Sends one command; the transfer completes at the rising edge without stall.
    // Valid stays high after the transfer so the next command can follow at
    // once; an idle gap or drain() takes it low.
    task automatic send_command(logic [1:0] cmd, logic [31:0] size, logic [31:0] faddr);
        int k;
        if (!calm && $urandom_range(0, 9) == 0) begin
            in_valid <= 1'b0;
            for (k = $urandom_range(1, 18); k > 0; k--) @(negedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        request_size <= size;
        free_address <= faddr;
        do @(posedge clk); while (in_stall);
        board.note_command(cmd, size, faddr);
        @(negedge clk);
    endtask

    // Blocks until every pending response has arrived, then lets the
    // allocator settle before a register write.
    task automatic drain();
        in_valid <= 1'b0;
        while (board.pending.size() != 0) @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    // Allocation size mostly a few blocks, sometimes large or odd.
    function automatic logic [31:0] pick_size();
        case ($urandom_range(0, 9))
            0:       return $urandom;
            1:       return 32'd0;
            2:       return $urandom_range(1, 4096);
            default: return $urandom_range(1, board.bsize * 6 + 1);
        endcase
    endfunction

    function automatic logic [31:0] pick_free_addr();
        int idx;
        case ($urandom_range(0, 5))
            0:       return $urandom;
            1:       return board.base + $urandom_range(0, 40) * board.bsize
                            + $urandom_range(0, 3);
            default: begin
                if (live_addrs.size() == 0) return board.base;
                idx = $urandom_range(0, live_addrs.size() - 1);
                pick_free_addr = live_addrs[idx];
                live_addrs.delete(idx);
            end
        endcase
    endfunction

    task automatic random_phase(int count);
        int k;
        for (k = 0; k < count; k++) begin
            case ($urandom_range(0, 19))
                0:        send_command(bba_pkg::CMD_INIT, $urandom, $urandom);
                1:        send_command(2'd3, $urandom, $urandom);
                2,3,4,5,6,7,8,9:
                          send_command(bba_pkg::CMD_FREE, $urandom, pick_free_addr());
                default:  send_command(bba_pkg::CMD_ALLOC, pick_size(), $urandom);
            endcase
        end
    endtask

    initial begin
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // Directed part at reset settings: fills, edges and bad requests.
        send_command(bba_pkg::CMD_ALLOC, 32'd0, 32'd0);
        send_command(bba_pkg::CMD_ALLOC, 32'd1, 32'd0);
        send_command(bba_pkg::CMD_ALLOC, 32'd17, 32'd0);
        send_command(bba_pkg::CMD_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_command(bba_pkg::CMD_ALLOC, 32'd16, 32'd0);
        send_command(bba_pkg::CMD_FREE, 32'd0, 32'd16);
        send_command(bba_pkg::CMD_FREE, 32'd0, 32'd16);
        send_command(bba_pkg::CMD_FREE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_command(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_command(bba_pkg::CMD_INIT, 32'd0, 32'd0);
        send_command(bba_pkg::CMD_FREE, 32'd0, 32'd0);
        send_command(bba_pkg::CMD_ALLOC, 32'd16384, 32'd0);
        send_command(bba_pkg::CMD_ALLOC, 32'd1, 32'd0);
        send_command(bba_pkg::CMD_INIT, 32'd0, 32'd0);

        // The sender holds off until the allocator has answered everything.
        drain();

        // Tiny pool with huge blocks and a high base: the reserve fills the pool.
        write_reg(bba_pkg::CFG_BASE, 32'hFFFF_FF00);
        write_reg(bba_pkg::CFG_BSIZE, 32'd65536);
        write_reg(bba_pkg::CFG_POOL, 32'd1);
        send_command(bba_pkg::CMD_INIT, 32'd0, 32'd0);
        send_command(bba_pkg::CMD_ALLOC, 32'd1, 32'd0);
        send_command(bba_pkg::CMD_FREE, 32'd0, 32'hFFFF_FF00);
        send_command(bba_pkg::CMD_ALLOC, 32'd1, 32'd0);
        send_command(bba_pkg::CMD_FREE, 32'd0, 32'h0000_0000);
        drain();

        // Pool larger than the tag store, one-byte blocks, zero block size.
        write_reg(bba_pkg::CFG_BASE, 32'h0000_1000);
        write_reg(bba_pkg::CFG_BSIZE, 32'd1);
        write_reg(bba_pkg::CFG_POOL, 32'd2047);
        send_command(bba_pkg::CMD_ALLOC, 32'd3, 32'd0);
        send_command(bba_pkg::CMD_FREE, 32'd0, 32'h0000_0FFF);
        drain();
        write_reg(bba_pkg::CFG_BSIZE, 32'd0);
        write_reg(bba_pkg::CFG_POOL, 32'd8);
        random_phase(60);
        drain();

        write_reg(bba_pkg::CFG_BASE, $urandom);
        write_reg(bba_pkg::CFG_BSIZE, 32'd16);
        write_reg(bba_pkg::CFG_POOL, 32'd64);
        live_addrs.delete();
        send_command(bba_pkg::CMD_INIT, 32'd0, 32'd0);
        random_phase(200);
        drain();

        write_reg(bba_pkg::CFG_BASE, 32'h8000_0000);
        write_reg(bba_pkg::CFG_BSIZE, $urandom_range(1, 100));
        write_reg(bba_pkg::CFG_POOL, $urandom_range(16, 200));
        live_addrs.delete();
        send_command(bba_pkg::CMD_INIT, 32'd0, 32'd0);
        random_phase(160);

        // Last stretch with no idling anywhere.
        calm = 1'b1;
        random_phase(100);

        drain();
        repeat (2200) @(negedge clk);
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
